// ===== hdl/lgle_pkg.sv =====
// Shared types and constants for the LPCM grouped to little-endian repacker.
package lgle_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_DEPTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 1'b1;

   localparam logic [1:0] DEPTH_16 = 2'd0;
   localparam logic [1:0] DEPTH_20 = 2'd1;
   localparam logic [1:0] DEPTH_24 = 2'd2;

   localparam logic [7:0] NIBBLE_HI_MASK = 8'hf0;
   localparam logic [7:0] NIBBLE_LO_MASK = 8'h0f;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_PAIR16  = 2'd0;
   localparam kind_type KIND_SPLIT20 = 2'd1;
   localparam kind_type KIND_WIDE24  = 2'd2;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  low_byte;
      logic [15:0] s0;
      logic [15:0] s1;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

// ===== hdl/lgle_req_if.sv =====
// Request channel carrying raw LPCM payload bytes.
interface lgle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hdl/lgle_rsp_if.sv =====
// Response channel carrying little-endian PCM bytes.
interface lgle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== hdl/lgle_front.sv =====
// Front end: configuration, block position tracking, sample store and command build.
module lgle_front #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [lgle_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lgle_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                              req_valid,
   input  logic [7:0]                        req_data_byte,
   output logic                              req_ready,
   input  logic                              queue_full,
   output lgle_pkg::push_type                push
);

   localparam int POS_W  = $clog2(6 * MAX_CHANNELS + 1);
   localparam int ROW_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int SIDX_W = ROW_W + 1;

   logic [1:0]                     depth_ff, depth_in;
   logic [lgle_pkg::CSR_DATA_W-1:0] count_ff, count_in;
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [1:0][15:0]               store_ff [MAX_CHANNELS];

   logic [POS_W-1:0]  ch;
   logic [POS_W-1:0]  hi_len;
   logic [POS_W-1:0]  block_len;
   logic [POS_W-1:0]  pos_cur;
   logic [POS_W-1:0]  pos_next;
   logic [POS_W-1:0]  offset;
   logic              in_hi;
   logic              depth_ok;
   logic [SIDX_W-1:0] sidx;
   logic [ROW_W-1:0]  row;
   logic [1:0][15:0]  row_data;
   logic [15:0]       sel;
   logic              accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (count_ff == '0) begin
         ch = POS_W'(1);
      end else if (count_ff > lgle_pkg::CSR_DATA_W'(MAX_CHANNELS)) begin
         ch = POS_W'(MAX_CHANNELS);
      end else begin
         ch = POS_W'(count_ff);
      end
   end

   assign hi_len = ch << 2;

   always_comb begin
      depth_ok = 1'b1;
      unique case (depth_ff)
         lgle_pkg::DEPTH_16: block_len = hi_len;
         lgle_pkg::DEPTH_20: block_len = hi_len + ch;
         lgle_pkg::DEPTH_24: block_len = hi_len + (ch << 1);
         default: begin
            block_len = hi_len;
            depth_ok  = 1'b0;
         end
      endcase
   end

   assign pos_cur  = (pos_ff >= block_len) ? '0 : pos_ff;
   assign in_hi    = pos_cur < hi_len;
   assign offset   = pos_cur - hi_len;
   assign pos_next = (pos_cur + POS_W'(1) >= block_len) ? '0 : pos_cur + POS_W'(1);

   // Upper bits index by byte pair; low bits by sample, or by sample pair at 20 bits.
   always_comb begin
      if (in_hi) begin
         sidx = pos_cur[SIDX_W:1];
      end else if (depth_ff == lgle_pkg::DEPTH_20) begin
         sidx = {offset[SIDX_W-2:0], 1'b0};
      end else begin
         sidx = offset[SIDX_W-1:0];
      end
   end

   assign row      = sidx[SIDX_W-1:1];
   assign row_data = store_ff[row];
   assign sel      = row_data[sidx[0]];

   always_comb begin
      push.valid        = accept && depth_ok &&
                          (in_hi ? (depth_ff == lgle_pkg::DEPTH_16 && pos_cur[0]) : 1'b1);
      push.cmd.low_byte = req_data_byte;
      push.cmd.s1       = row_data[1];
      if (in_hi) begin
         push.cmd.kind = lgle_pkg::KIND_PAIR16;
         push.cmd.s0   = {sel[15:8], req_data_byte};
      end else begin
         push.cmd.kind = (depth_ff == lgle_pkg::DEPTH_20) ? lgle_pkg::KIND_SPLIT20
                                                          : lgle_pkg::KIND_WIDE24;
         push.cmd.s0   = sel;
      end
   end

   always_comb begin
      depth_in = depth_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            lgle_pkg::CSR_SAMPLE_DEPTH:  depth_in = csr_write_data[1:0];
            lgle_pkg::CSR_CHANNEL_COUNT: count_in = csr_write_data;
            default: ;
         endcase
         pos_in = '0;
      end else if (accept) begin
         pos_in = depth_ok ? pos_next : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= lgle_pkg::DEPTH_16;
         count_ff <= lgle_pkg::CSR_DATA_W'(2);
         pos_ff   <= '0;
      end else begin
         depth_ff <= depth_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && depth_ok && in_hi) begin
         store_ff[row][sidx[0]] <= pos_cur[0] ? {sel[15:8], req_data_byte}
                                              : {req_data_byte, 8'h00};
      end
   end

endmodule

// ===== hdl/lgle_queue.sv =====
// Two-entry command queue between the front end and the byte emitter.
module lgle_queue (
   input  logic               clock,
   input  logic               reset,
   input  lgle_pkg::push_type push,
   output logic               full,
   output lgle_pkg::head_type head,
   input  logic               pop
);

   localparam int DEPTH = 2;

   lgle_pkg::cmd_type entry_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = count_ff == 2'(DEPTH);
   assign head.valid = count_ff != '0;
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("queue count exceeds depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full))
      else $error("front pushed into a full queue");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == 2'(DEPTH)) == (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// ===== hdl/lgle_back.sv =====
// Back end: expands each queued command into its little-endian output bytes.
module lgle_back (
   input  logic               clock,
   input  logic               reset,
   input  lgle_pkg::head_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_of_run
);

   logic [2:0] step_ff, step_in;
   logic [2:0] len;
   logic       fire;
   lgle_pkg::cmd_type cmd;

   assign cmd       = head.cmd;
   assign rsp_valid = head.valid;
   assign fire      = rsp_valid && rsp_ready;

   always_comb begin
      unique case (cmd.kind)
         lgle_pkg::KIND_PAIR16:  len = 3'd2;
         lgle_pkg::KIND_SPLIT20: len = 3'd6;
         default:                len = 3'd3;
      endcase
   end

   assign rsp_last_of_run = step_ff == len - 3'd1;
   assign pop             = fire && rsp_last_of_run;

   // Each 20/24-bit sample leaves low, middle, high byte; 16-bit ones low, high.
   always_comb begin
      rsp_out_byte = cmd.s0[15:8];
      unique case (cmd.kind)
         lgle_pkg::KIND_PAIR16: begin
            rsp_out_byte = (step_ff == 3'd0) ? cmd.s0[7:0] : cmd.s0[15:8];
         end
         lgle_pkg::KIND_SPLIT20: begin
            unique case (step_ff)
               3'd0:    rsp_out_byte = cmd.low_byte & lgle_pkg::NIBBLE_HI_MASK;
               3'd1:    rsp_out_byte = cmd.s0[7:0];
               3'd2:    rsp_out_byte = cmd.s0[15:8];
               3'd3:    rsp_out_byte = (cmd.low_byte & lgle_pkg::NIBBLE_LO_MASK) << 4;
               3'd4:    rsp_out_byte = cmd.s1[7:0];
               default: rsp_out_byte = cmd.s1[15:8];
            endcase
         end
         default: begin
            unique case (step_ff)
               3'd0:    rsp_out_byte = cmd.low_byte;
               3'd1:    rsp_out_byte = cmd.s0[7:0];
               default: rsp_out_byte = cmd.s0[15:8];
            endcase
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (fire) begin
         step_in = rsp_last_of_run ? '0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> step_ff < len)
      else $error("emit step beyond command length");

endmodule

// ===== hdl/lpcm_grouped_to_little_endian_unit.sv =====
// DVD LPCM byte stream to little-endian PCM byte stream repacker.
//
// The req_chan sink takes one payload byte per request; the rsp_chan source
// returns PCM bytes, with last_of_run marking the final byte caused by a request.
// The csr_ port sets the sample depth (index 0) and channel count (index 1);
// any write restarts block alignment with the next byte.
//
// The front end accepts one byte per cycle while its two-entry command queue has
// room. Bytes that complete a 16-bit sample, or low-bit bytes in 20/24-bit mode,
// become queue commands; upper-bit bytes in 20/24-bit mode only fill the store.
// Each command is registered in the queue before its first output byte appears.
// The back end emits one byte per cycle while the receiver is ready: 2 bytes
// per 16-bit sample, 6 per 20-bit low byte, 3 per 24-bit low byte, so sustained
// throughput is one byte per cycle in 16-bit mode; the emitter sets it otherwise.
// When the receiver stalls the queue fills and req_chan.ready drops.
// Reset selects 16-bit depth with two channels and empties the queue.
module lpcm_grouped_to_little_endian_unit #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [lgle_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lgle_pkg::CSR_DATA_W-1:0]  csr_write_data,
   lgle_req_if.sink                         req_chan,
   lgle_rsp_if.source                       rsp_chan
);

   lgle_pkg::push_type push;
   lgle_pkg::head_type head;
   logic               queue_full;
   logic               pop;

   lgle_front #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_chan.valid),
      .req_data_byte    (req_chan.data_byte),
      .req_ready        (req_chan.ready),
      .queue_full       (queue_full),
      .push             (push)
   );

   lgle_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   lgle_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_out_byte    (rsp_chan.out_byte),
      .rsp_last_of_run (rsp_chan.last_of_run)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LPCM grouped to little-endian repacker.
module tb;

   localparam int MAX_CHANNELS = 8;
   localparam int unsigned RANDOM_BYTES = 460;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam logic [1:0] DEPTH_RESERVED = 2'd3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } pcm_byte_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_write_enable;
   logic [lgle_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lgle_pkg::CSR_DATA_W-1:0]  csr_write_data;

   lgle_req_if req_chan ();
   lgle_rsp_if rsp_chan ();

   lpcm_grouped_to_little_endian_unit #(
      .MAX_CHANNELS(MAX_CHANNELS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // Shadow of the repacker: settings, buffered sample tops and block offset.
   logic [1:0]   depth_code;
   logic [3:0]   channel_code;
   logic [15:0]  sample_hi [2*MAX_CHANNELS];
   logic [5:0]   block_pos;
   logic [7:0]   run_bytes [$];
   pcm_byte_type pcm_expected [$];
   pcm_byte_type pcm_want;
   logic [7:0]   payload_queue [$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          calm = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned active_channels();
      if (channel_code == 4'd0) return 1;
      if (channel_code > MAX_CHANNELS) return MAX_CHANNELS;
      return channel_code;
   endfunction

   function automatic int unsigned block_bytes();
      int unsigned ch;
      ch = active_channels();
      case (depth_code)
         lgle_pkg::DEPTH_16: return 4 * ch;
         lgle_pkg::DEPTH_20: return 5 * ch;
         lgle_pkg::DEPTH_24: return 6 * ch;
         default: return 0;
      endcase
   endfunction

   function automatic void add_sample(logic [7:0] low_bits, int unsigned idx);
      run_bytes.push_back(low_bits);
      run_bytes.push_back(sample_hi[idx][7:0]);
      run_bytes.push_back(sample_hi[idx][15:8]);
   endfunction

   // Advances the shadow by one payload byte and queues the PCM bytes it yields.
   function automatic void repack_byte(logic [7:0] b);
      int unsigned  hi_len;
      int unsigned  blk_len;
      int unsigned  pos;
      int unsigned  j;
      pcm_byte_type item;
      hi_len = 4 * active_channels();
      blk_len = block_bytes();
      run_bytes.delete();
      if (blk_len == 0) begin
         block_pos = '0;
         return;
      end
      pos = block_pos;
      if (pos >= blk_len) pos = 0;
      if (pos < hi_len) begin
         if (pos % 2 == 0) begin
            sample_hi[pos/2] = {b, 8'h00};
         end else begin
            sample_hi[pos/2][7:0] = b;
            if (depth_code == lgle_pkg::DEPTH_16) begin
               run_bytes.push_back(b);
               run_bytes.push_back(sample_hi[pos/2][15:8]);
            end
         end
      end else if (depth_code == lgle_pkg::DEPTH_20) begin
         // One low byte carries the bottom nibbles of a sample pair.
         j = pos - hi_len;
         add_sample(b & lgle_pkg::NIBBLE_HI_MASK, 2 * j);
         add_sample((b & lgle_pkg::NIBBLE_LO_MASK) << 4, 2 * j + 1);
      end else begin
         add_sample(b, pos - hi_len);
      end
      pos = pos + 1;
      if (pos >= blk_len) pos = 0;
      block_pos = 6'(pos);
      foreach (run_bytes[i]) begin
         item.out_byte = run_bytes[i];
         item.last_of_run = (i == run_bytes.size() - 1);
         pcm_expected.push_back(item);
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic wait_idle();
      @(negedge clock);
      while (payload_queue.size() != 0 || req_chan.valid || pcm_expected.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [lgle_pkg::CSR_INDEX_W-1:0] idx,
                            logic [lgle_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      if (idx == lgle_pkg::CSR_SAMPLE_DEPTH) depth_code = value[1:0];
      else channel_code = value;
      block_pos = '0;
   endtask

   task automatic configure(bit set_depth, logic [3:0] depth_value,
                            bit set_channels, logic [3:0] channel_value);
      wait_idle();
      if (set_depth) write_reg(lgle_pkg::CSR_SAMPLE_DEPTH, depth_value);
      if (set_channels) write_reg(lgle_pkg::CSR_CHANNEL_COUNT, channel_value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) repack_byte(req_chan.data_byte);
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap > 0 || payload_queue.size() == 0) begin
               req_chan.valid <= 1'b0;
               if (req_gap > 0) req_gap--;
            end else begin
               req_chan.valid <= 1'b1;
               req_chan.data_byte <= payload_queue.pop_front();
               req_gap = calm ? 0 : pick_gap();
            end
         end
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pcm_expected.size() == 0) begin
               error_count++;
               $display("%0t: expected no PCM byte, got out_byte %h last_of_run %b",
                        $time, rsp_chan.out_byte, rsp_chan.last_of_run);
            end else begin
               pcm_want = pcm_expected.pop_front();
               if (rsp_chan.out_byte !== pcm_want.out_byte) begin
                  error_count++;
                  $display("%0t: out_byte expected %h, got %h",
                           $time, pcm_want.out_byte, rsp_chan.out_byte);
               end
               if (rsp_chan.last_of_run !== pcm_want.last_of_run) begin
                  error_count++;
                  $display("%0t: last_of_run expected %b, got %b",
                           $time, pcm_want.last_of_run, rsp_chan.last_of_run);
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
            rsp_stall = calm ? 0 : pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned random_sent;
      int unsigned phase;
      int unsigned blk;
      int unsigned count;
      int unsigned r;
      bit          set_depth;
      bit          set_channels;
      logic [1:0]  depth_pick;
      logic [3:0]  channel_pick;

      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = lgle_pkg::CSR_SAMPLE_DEPTH;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      rsp_chan.ready = 1'b0;
      depth_code = lgle_pkg::DEPTH_16;
      channel_code = 4'd2;
      block_pos = '0;
      foreach (sample_hi[i]) sample_hi[i] = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings, 16-bit with two channels; the block is left partly done.
      payload_queue = '{8'h00, 8'hff, 8'hff, 8'h00, 8'h80, 8'h7f};
      // A channel count of zero acts as one; the write also restarts the block.
      configure(1'b1, {2'b01, lgle_pkg::DEPTH_20}, 1'b1, 4'd0);
      payload_queue = '{8'hff, 8'h00, 8'h5a, 8'ha5, 8'hf0};
      configure(1'b1, {2'b10, lgle_pkg::DEPTH_24}, 1'b0, 4'd0);
      payload_queue = '{8'h12, 8'h34, 8'hab, 8'hcd, 8'h0f, 8'hff};
      // The reserved depth code swallows bytes without output.
      configure(1'b1, {2'b11, DEPTH_RESERVED}, 1'b0, 4'd0);
      payload_queue = '{8'h55, 8'haa};
      configure(1'b1, {2'b00, lgle_pkg::DEPTH_16}, 1'b1, 4'd1);
      payload_queue = '{8'hf0, 8'h0f, 8'hc3, 8'h3c};

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_BYTES) begin
         case (phase)
            0: configure(1'b1, {2'($urandom_range(0, 3)), lgle_pkg::DEPTH_24},
                         1'b1, 4'd15);
            1: configure(1'b1, {2'($urandom_range(0, 3)), lgle_pkg::DEPTH_20}, 1'b1,
                         4'(MAX_CHANNELS));
            default: begin
               r = $urandom_range(0, 9);
               if (r < 3) depth_pick = lgle_pkg::DEPTH_16;
               else if (r < 6) depth_pick = lgle_pkg::DEPTH_20;
               else if (r < 9) depth_pick = lgle_pkg::DEPTH_24;
               else depth_pick = DEPTH_RESERVED;
               if ($urandom_range(0, 3) == 0) channel_pick = 4'($urandom_range(0, 15));
               else channel_pick = 4'($urandom_range(1, 4));
               set_depth = 1'($urandom_range(0, 1));
               set_channels = 1'($urandom_range(0, 1));
               if (!set_depth && !set_channels) set_depth = 1'b1;
               configure(set_depth, {2'($urandom_range(0, 3)), depth_pick},
                         set_channels, channel_pick);
            end
         endcase
         calm = ($urandom_range(0, 4) == 0);
         blk = block_bytes();
         if (blk == 0) begin
            count = $urandom_range(1, 6);
         end else begin
            count = blk * $urandom_range(1, 3);
            // Now and then leave a block unfinished for the next write to cut off.
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, blk - 1);
            random_sent += count;
         end
         repeat (count) payload_queue.push_back(8'($urandom_range(0, 255)));
         phase++;
      end

      wait_idle();
      repeat (20) @(negedge clock);
      if (error_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule
